@@ design/rwt_pkg.sv @@
package rwt_pkg;

   // Input command codes.
   localparam logic CMD_ENTER = 1'b0;
   localparam logic CMD_TIMER = 1'b1;

   // All-ones values for priority and time.
   localparam logic [31:0] PRIO_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [63:0] TIME_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_READY = 2'd0,
      KIND_SLEEP = 2'd1,
      KIND_EVENT = 2'd2,
      KIND_FULL  = 2'd3
   } kind_type;

   // One input item.
   typedef struct packed {
      logic        command;
      logic [7:0]  thread_id;
      logic        first_instance;
      logic [31:0] period;
      logic [31:0] given_priority;
      logic [63:0] arrival_time;
      logic [63:0] current_time;
      logic [31:0] ready_head_priority;
      logic        ready_empty;
   } req_type;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_thread_id;
      logic [31:0] out_priority;
      logic [63:0] event_time;
      logic        last;
   } rsp_type;

   // One sleep table entry as kept in the slot memory.
   typedef struct packed {
      logic [63:0] wake_time;
      logic [31:0] priority_val;
      logic [7:0]  thread;
   } slot_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic enter;
      logic scan_rd;
      logic finish;
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_last;
   } ctrl_stat_type;

endpackage

@@ design/rate_monotonic_wakeup_timer.sv @@
// Channel   Handshake               Payload
// input     start / busy            req_item  (rwt_pkg::req_type)
// result    rsp_strobe (one cycle)  rsp_item  (rwt_pkg::rsp_type)
//
// An enter item is accepted, its single result is registered in the enter state,
// and the next item may be accepted once busy falls at the end of that state.
// A timer item reads one slot a cycle through the single read port of the
// slot memory; its final event result follows the last and final states.
// Reset is synchronous and clears the valid bits; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rate_monotonic_wakeup_timer #(
   parameter int SLEEP_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rwt_pkg::req_type req_item,
   output logic             rsp_strobe,
   output rwt_pkg::rsp_type rsp_item
);

   import rwt_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Sequencer.
   rwt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_item.command),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   // Slot table and result datapath.
   rwt_datapath #(
      .SLEEP_SLOTS (SLEEP_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

@@ design/rwt_ram.sv @@
module rwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rwt_ctrl.sv @@
module rwt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  command,
   input  rwt_pkg::ctrl_stat_type stat,
   output rwt_pkg::ctrl_cmd_type  cmd,
   output logic                  busy
);

   import rwt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENTER,
      ST_SCAN,
      ST_LAST,
      ST_FINAL
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (command == CMD_TIMER) ? ST_SCAN : ST_ENTER;
            end
         end
         ST_ENTER: state_in = ST_IDLE;
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:  state_in = ST_FINAL;
         ST_FINAL: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath follow from the state.
   always_comb begin
      cmd         = '0;
      cmd.load    = (state_ff == ST_IDLE) && start;
      cmd.enter   = (state_ff == ST_ENTER);
      cmd.scan_rd = (state_ff == ST_SCAN);
      cmd.finish  = (state_ff == ST_FINAL);
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ design/rwt_datapath.sv @@
module rwt_datapath #(
   parameter int SLEEP_SLOTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rwt_pkg::req_type       req_item,
   input  rwt_pkg::ctrl_cmd_type  cmd,
   output rwt_pkg::ctrl_stat_type stat,
   output logic                   rsp_strobe,
   output rwt_pkg::rsp_type       rsp_item
);

   import rwt_pkg::*;

   localparam int SLOT_AW = (SLEEP_SLOTS > 1) ? $clog2(SLEEP_SLOTS) : 1;
   localparam int SLOT_W  = $bits(slot_type);

   req_type                req_ff;
   logic [SLEEP_SLOTS-1:0] valid_ff;
   logic [SLEEP_SLOTS-1:0] valid_in;
   logic [SLOT_AW-1:0]     idx_ff;
   logic [SLOT_AW-1:0]     idx_in;
   logic [SLOT_AW-1:0]     addr_ff;
   logic                   eval_ff;
   logic [63:0]            best_ff;
   logic [63:0]            best_in;
   logic [31:0]            running_ff;
   logic [31:0]            running_in;
   logic                   strobe_ff;
   logic                   strobe_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [SLOT_W-1:0]      rd_data;
   slot_type               slot;
   slot_type               new_slot;
   logic [31:0]            prio_calc;
   logic                   sleep_req;
   logic                   free_found;
   logic [SLOT_AW-1:0]     free_idx;
   logic                   wr_en;
   logic                   hit;
   logic                   due;
   logic                   compete;

   // Slot payload memory; valid bits stay in flip-flops.
   rwt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLEEP_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx),
      .wr_data (new_slot),
      .rd_en   (cmd.scan_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Priority of an entering thread and whether it goes to sleep.
   always_comb begin
      prio_calc = req_ff.given_priority;
      if (req_ff.first_instance && (req_ff.period != 32'd0)) begin
         prio_calc = PRIO_ALL_ONES - req_ff.period;
      end
      sleep_req = req_ff.first_instance && (req_ff.arrival_time != 64'd0);
   end

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLEEP_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_AW'(i);
         end
      end
   end

   assign wr_en                 = cmd.enter && sleep_req && free_found;
   assign new_slot.wake_time    = req_ff.arrival_time;
   assign new_slot.priority_val = prio_calc;
   assign new_slot.thread       = req_ff.thread_id;

   // Evaluation of the slot read in the previous cycle.
   always_comb begin
      slot    = slot_type'(rd_data);
      hit     = eval_ff && valid_ff[addr_ff];
      due     = (slot.wake_time <= req_ff.current_time);
      compete = hit && !due && (slot.wake_time <= best_ff) &&
                (slot.priority_val >= running_ff);
   end

   // Next values of the scan state, valid bits and result register.
   always_comb begin
      valid_in   = valid_ff;
      idx_in     = idx_ff;
      best_in    = best_ff;
      running_in = running_ff;
      strobe_in  = 1'b0;
      rsp_in     = '0;

      if (cmd.load) begin
         idx_in     = '0;
         best_in    = TIME_ALL_ONES;
         running_in = req_item.ready_empty ? 32'd0 : req_item.ready_head_priority;
      end
      if (cmd.scan_rd) begin
         idx_in = idx_ff + SLOT_AW'(1);
      end

      // Enter: sleep, table full or ready.
      if (cmd.enter) begin
         strobe_in            = 1'b1;
         rsp_in.out_thread_id = req_ff.thread_id;
         rsp_in.out_priority  = prio_calc;
         rsp_in.last          = 1'b1;
         if (!sleep_req) begin
            rsp_in.kind = KIND_READY;
         end else if (free_found) begin
            rsp_in.kind        = KIND_SLEEP;
            valid_in[free_idx] = 1'b1;
         end else begin
            rsp_in.kind = KIND_FULL;
         end
      end

      // Timer scan: wake due slots, track the earliest competing wake time.
      if (hit && due) begin
         valid_in[addr_ff]    = 1'b0;
         strobe_in            = 1'b1;
         rsp_in.kind          = KIND_READY;
         rsp_in.out_thread_id = slot.thread;
         rsp_in.out_priority  = slot.priority_val;
         if (slot.priority_val > running_ff) begin
            running_in = slot.priority_val;
         end
      end
      if (compete) begin
         best_in = slot.wake_time;
      end

      if (cmd.finish) begin
         strobe_in         = 1'b1;
         rsp_in.kind       = KIND_EVENT;
         rsp_in.event_time = best_ff;
         rsp_in.last       = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         eval_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         eval_ff   <= cmd.scan_rd;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      idx_ff     <= idx_in;
      addr_ff    <= idx_ff;
      best_ff    <= best_in;
      running_ff <= running_in;
      rsp_ff     <= rsp_in;
   end

   assign stat.scan_last = (idx_ff == SLOT_AW'(SLEEP_SLOTS - 1));
   assign rsp_strobe     = strobe_ff;
   assign rsp_item       = rsp_ff;

endmodule

@@ design/rwt_checker.sv @@
module rwt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input rwt_pkg::req_type req_item,
   input logic             rsp_strobe,
   input rwt_pkg::rsp_type rsp_item
);

   import rwt_pkg::*;

   // A result follows a cycle in which the block was working.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without preceding busy cycle");

   // An accepted enter item yields its final result after the enter state.
   a_enter_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.command == CMD_ENTER)) |=> ##1
      (rsp_strobe && rsp_item.last))
      else $error("enter item result missing");

   // The timer event result closes its item.
   a_event_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.kind == KIND_EVENT)) |-> rsp_item.last)
      else $error("timer event result not marked last");

   // No result directly follows the last result of an item.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |=> !rsp_strobe)
      else $error("result directly after last result");

endmodule

bind rate_monotonic_wakeup_timer rwt_checker u_rwt_checker (.*);

@@ dv/rate_monotonic_wakeup_timer_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the wakeup timer, keeps its own copy of the sleep
// table, and compares every result with the oldest one still owed.
module rate_monotonic_wakeup_timer_checker #(
   parameter int SLEEP_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  rwt_pkg::req_type req_item,
   input  logic             rsp_strobe,
   input  rwt_pkg::rsp_type rsp_item,
   output int               error_count,
   output int               pending_count,
   output int               checked_count,
   output int               woken_count,
   output int               full_count
);

   import rwt_pkg::*;

   // Shadow sleep table.
   logic        slot_taken [SLEEP_SLOTS];
   logic [63:0] slot_due   [SLEEP_SLOTS];
   logic [31:0] slot_prio  [SLEEP_SLOTS];
   logic [7:0]  slot_tid   [SLEEP_SLOTS];

   // Results owed by the block, oldest first.
   rsp_type owed_results[$];
   rsp_type oldest;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      error_count++;
   endtask

   // Work out the results of one accepted item and update the shadow table.
   task automatic schedule_item(input req_type r);
      rsp_type     res;
      logic [31:0] prio;
      logic [31:0] floor_prio;
      logic [63:0] earliest;
      int          i;
      if (r.command == CMD_ENTER) begin
         prio = r.given_priority;
         if (r.first_instance && r.period != '0) begin
            prio = PRIO_ALL_ONES - r.period;
         end
         res = '0;
         res.kind = KIND_READY;
         res.out_thread_id = r.thread_id;
         res.out_priority = prio;
         res.last = 1'b1;
         // Only a first instance with an arrival time goes to sleep.
         if (r.first_instance && r.arrival_time != '0) begin
            res.kind = KIND_FULL;
            for (i = 0; i < SLEEP_SLOTS; i++) begin
               if (!slot_taken[i]) begin
                  slot_taken[i] = 1'b1;
                  slot_due[i] = r.arrival_time;
                  slot_prio[i] = prio;
                  slot_tid[i] = r.thread_id;
                  res.kind = KIND_SLEEP;
                  break;
               end
            end
            if (res.kind == KIND_FULL) begin
               full_count++;
            end
         end
         owed_results.push_back(res);
      end else begin
         earliest = TIME_ALL_ONES;
         floor_prio = r.ready_empty ? 32'd0 : r.ready_head_priority;
         // Wake due threads in slot order; the ready head rises as they go.
         for (i = 0; i < SLEEP_SLOTS; i++) begin
            if (slot_taken[i]) begin
               if (slot_due[i] <= r.current_time) begin
                  slot_taken[i] = 1'b0;
                  res = '0;
                  res.kind = KIND_READY;
                  res.out_thread_id = slot_tid[i];
                  res.out_priority = slot_prio[i];
                  owed_results.push_back(res);
                  woken_count++;
                  if (slot_prio[i] > floor_prio) begin
                     floor_prio = slot_prio[i];
                  end
               end else if (slot_due[i] <= earliest && slot_prio[i] >= floor_prio) begin
                  earliest = slot_due[i];
               end
            end
         end
         res = '0;
         res.kind = KIND_EVENT;
         res.event_time = earliest;
         res.last = 1'b1;
         owed_results.push_back(res);
      end
   endtask

   // Results are checked before the item accepted at the same edge is added.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLEEP_SLOTS; i++) begin
            slot_taken[i] = 1'b0;
         end
         owed_results.delete();
         pending_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (owed_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d tid %0h",
                                         rsp_item.kind, rsp_item.out_thread_id));
            end else begin
               oldest = owed_results.pop_front();
               checked_count++;
               if (rsp_item !== oldest) begin
                  report_mismatch($sformatf(
                     "got %0d/%0h/%0h/%0h/%0b want %0d/%0h/%0h/%0h/%0b",
                     rsp_item.kind, rsp_item.out_thread_id, rsp_item.out_priority,
                     rsp_item.event_time, rsp_item.last, oldest.kind,
                     oldest.out_thread_id, oldest.out_priority, oldest.event_time,
                     oldest.last));
               end
            end
         end
         if (start && !busy) begin
            schedule_item(req_item);
         end
         pending_count <= owed_results.size();
      end
   end

endmodule

@@ dv/rate_monotonic_wakeup_timer_tb.sv @@
`timescale 1ns / 1ps

module rate_monotonic_wakeup_timer_tb;

   import rwt_pkg::*;

   localparam int SLOTS = 16;
   localparam int RANDOM_ITEMS = 350;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int error_count;
   int pending_count;
   int checked_count;
   int woken_count;
   int full_count;
   int items_sent;
   int burst_left;

   // Time base that sleeping arrivals and most timer items follow.
   logic [63:0] sys_time;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rate_monotonic_wakeup_timer #(
      .SLEEP_SLOTS (SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   rate_monotonic_wakeup_timer_checker #(
      .SLEEP_SLOTS (SLOTS)
   ) rsp_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .woken_count   (woken_count),
      .full_count    (full_count)
   );

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Every field random, so that the fields an item does not use still toggle.
   function automatic req_type random_req();
      req_type r;
      r.command = 1'($urandom_range(0, 1));
      r.thread_id = 8'($urandom);
      r.first_instance = 1'($urandom_range(0, 1));
      r.period = $urandom;
      r.given_priority = $urandom;
      r.arrival_time = rand64();
      r.current_time = rand64();
      r.ready_head_priority = $urandom;
      r.ready_empty = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic req_type enter_req(input logic [7:0] tid, input logic first,
                                         input logic [31:0] period,
                                         input logic [31:0] given,
                                         input logic [63:0] arrival);
      req_type r;
      r = random_req();
      r.command = CMD_ENTER;
      r.thread_id = tid;
      r.first_instance = first;
      r.period = period;
      r.given_priority = given;
      r.arrival_time = arrival;
      return r;
   endfunction

   function automatic req_type timer_req(input logic [63:0] now,
                                         input logic [31:0] head,
                                         input logic no_ready);
      req_type r;
      r = random_req();
      r.command = CMD_TIMER;
      r.current_time = now;
      r.ready_head_priority = head;
      r.ready_empty = no_ready;
      return r;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a burst with none.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (roll < 5) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Hold the item until it is taken, then idle for a random gap.
   task automatic send_item(input req_type item);
      int gap;
      req_item <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Edge cases: empty table, every enter path, a full table, partial and
   // complete wakeups, duplicate thread ids and all-ones times.
   task automatic run_directed();
      logic [31:0] per;
      logic [31:0] given;
      logic [63:0] arrival;
      logic [7:0]  tid;
      send_item(timer_req(TIME_ALL_ONES, $urandom, 1'b1));
      send_item(enter_req(8'h00, 1'b1, 32'd0, 32'h1234_5678, 64'd0));
      send_item(enter_req(8'h01, 1'b1, 32'd1, $urandom, 64'd0));
      send_item(enter_req(8'h02, 1'b0, 32'd5, 32'h0000_0042, 64'd77));
      send_item(enter_req(8'hFF, 1'b0, PRIO_ALL_ONES, PRIO_ALL_ONES, TIME_ALL_ONES));
      for (int i = 0; i < SLOTS; i++) begin
         per = (i == 0) ? PRIO_ALL_ONES : (i == 1) ? 32'd0 : 32'(i * 3);
         given = (i == 1) ? PRIO_ALL_ONES : $urandom;
         arrival = (i == SLOTS - 1) ? TIME_ALL_ONES : 64'(100 + i * 10);
         tid = (i == SLOTS - 1) ? 8'hFF : 8'(i % 4);
         send_item(enter_req(tid, 1'b1, per, given, arrival));
      end
      send_item(enter_req(8'hAA, 1'b1, 32'd7, $urandom, 64'd500));
      send_item(timer_req(64'd0, PRIO_ALL_ONES, 1'b0));
      send_item(timer_req(64'd135, 32'd0, 1'b0));
      send_item(timer_req(TIME_ALL_ONES, $urandom, 1'b1));
   endtask

   function automatic logic [31:0] pick_period();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return 32'd0;
      if (roll < 65) return $urandom_range(1, 300);
      if (roll < 90) return $urandom;
      return PRIO_ALL_ONES;
   endfunction

   // Sleeping enters near the time base and timers that advance it, so that
   // threads wake, compete and at times fill the table.
   task automatic run_random();
      int          roll;
      int          pick;
      logic [63:0] now;
      logic [63:0] arrival;
      logic [31:0] head;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               sys_time = sys_time + $urandom_range(0, 120);
               now = sys_time;
            end else if (pick < 95) begin
               now = rand64();
            end else begin
               now = TIME_ALL_ONES;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) head = PRIO_ALL_ONES - $urandom_range(0, 400);
            else if (pick < 70) head = $urandom;
            else head = 32'd0;
            send_item(timer_req(now, head, $urandom_range(0, 99) < 30));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) arrival = 64'd0;
            else if (pick < 80) arrival = sys_time + $urandom_range(1, 300);
            else if (pick < 93) arrival = rand64();
            else arrival = TIME_ALL_ONES;
            send_item(enter_req(8'($urandom), $urandom_range(0, 99) < 70, pick_period(),
                                $urandom, arrival));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      items_sent = 0;
      burst_left = 0;
      sys_time = 64'd1000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      start <= 1'b0;
      // Drain every owed result, then allow one full scan for stray strobes.
      do @(posedge clock); while (pending_count != 0);
      repeat (SLOTS + 8) @(posedge clock);
      $display("Summary: %0d items accepted, %0d results checked.", items_sent,
               checked_count);
      $display("Summary: %0d thread wakeups and %0d table-full results seen.",
               woken_count, full_count);
      if (error_count == 0) begin
         $display("rate_monotonic_wakeup_timer_tb: clean");
      end else begin
         $display("rate_monotonic_wakeup_timer_tb: errors");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results still owed.", pending_count);
      $display("rate_monotonic_wakeup_timer_tb: errors");
      $finish;
   end

endmodule
